// ----- design/lpwv_pkg.sv -----
// Shared constants and types for the pattern write/verify block.
`default_nettype none

package lpwv_pkg;

    // Width of the byte position counter; drive size is taken modulo 2^POSITION_BITS
    localparam int POSITION_BITS = 48;

    // Configuration register widths
    localparam int DRIVE_SIZE_BITS = 48;
    localparam int REG_IDX_BITS    = 1;
    localparam int REG_DATA_BITS   = DRIVE_SIZE_BITS;

    // Word and generator widths
    localparam int WORD_BITS  = 32;
    localparam int LCG_BITS   = 31;
    localparam int MUL_BITS   = 15;
    localparam int PROD_BITS  = LCG_BITS + MUL_BITS;
    localparam int VALID_BITS = 3;
    localparam int WORD_BYTES = WORD_BITS / 8;

    // Lehmer generator constants
    localparam logic [WORD_BITS-1:0] LCG_MOD  = 32'h7fff_ffff;
    localparam logic [MUL_BITS-1:0]  LCG_MUL  = 15'd16807;
    localparam logic [LCG_BITS-1:0]  LCG_SEED = 31'h6a65_6272;

    // Configuration register indexes
    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_DRIVE_SIZE  = 1'b0,
        REG_VERIFY_MODE = 1'b1
    } reg_idx_t;

endpackage

`default_nettype wire

// ----- design/lcg_pattern_write_verify.sv -----
// Erase pattern generator and checker: Lehmer word stream with byte-range verify.
// Each result is registered in the cycle after its input word is accepted.
// Throughput: one word per cycle unless out_ready stalls; the generator multiply,
// its Mersenne reduction and the 48-bit position compare all sit in the single accept-to-result stage.
// Reset: generator returns to the fixed seed, position and sticky error clear,
// drive size and verify mode clear, no result is pending. No clearing pass.
`default_nettype none

module lcg_pattern_write_verify (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // configuration write port
    input  wire logic                                   wr_en,
    input  wire logic [lpwv_pkg::REG_IDX_BITS-1:0]      wr_index,
    input  wire logic [lpwv_pkg::REG_DATA_BITS-1:0]     wr_data,
    // input words
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic [lpwv_pkg::WORD_BITS-1:0]         read_word,
    input  wire logic                                   restart,
    // result words
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic [lpwv_pkg::LCG_BITS-1:0]               pattern_word,
    output logic [lpwv_pkg::VALID_BITS-1:0]             valid_bytes,
    output logic                                        word_mismatch,
    output logic                                        error_seen,
    output logic                                        last
);
    import lpwv_pkg::*;

    // configuration
    logic [DRIVE_SIZE_BITS-1:0] drive_size_reg;
    logic                       verify_mode_reg;

    // generator state
    logic [LCG_BITS-1:0]      lcg_reg;
    logic [POSITION_BITS-1:0] pos_reg;
    logic                     err_reg;

    // result register
    logic                   out_valid_reg;
    logic [LCG_BITS-1:0]    pattern_reg;
    logic [VALID_BITS-1:0]  valid_bytes_reg;
    logic                   mismatch_reg;
    logic                   error_reg;
    logic                   last_reg;

    // combinational stage
    logic                     accept;
    logic [LCG_BITS-1:0]      lcg_cur;
    logic [POSITION_BITS-1:0] pos_cur;
    logic                     err_cur;
    logic [POSITION_BITS-1:0] end_pos;
    logic [POSITION_BITS-1:0] remain;
    logic                     active;
    logic [PROD_BITS-1:0]     prod;
    logic [WORD_BITS-1:0]     fold;
    logic [LCG_BITS-1:0]      lcg_new;
    logic [VALID_BITS-1:0]    valid_cnt;
    logic                     is_last;
    logic [WORD_BITS-1:0]     pat_word;
    logic                     mismatch;

    // output register frees up whenever its word is taken
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // restart applies before this word
    assign lcg_cur = restart ? LCG_SEED : lcg_reg;
    assign pos_cur = restart ? '0 : pos_reg;
    assign err_cur = restart ? 1'b0 : err_reg;

    // range check against the drive end
    assign end_pos = POSITION_BITS'(drive_size_reg);
    assign active  = pos_cur < end_pos;
    assign remain  = end_pos - pos_cur;

    always_comb
    begin
        if (!active)
        begin
            valid_cnt = '0;
            is_last   = 1'b1;
        end
        else if (remain >= POSITION_BITS'(WORD_BYTES))
        begin
            valid_cnt = VALID_BITS'(WORD_BYTES);
            is_last   = remain == POSITION_BITS'(WORD_BYTES);
        end
        else
        begin
            valid_cnt = remain[VALID_BITS-1:0];
            is_last   = 1'b1;
        end
    end

    // x * 16807 mod 2^31-1: fold the high bits back in, one conditional subtract
    assign prod    = PROD_BITS'(lcg_cur) * PROD_BITS'(LCG_MUL);
    assign fold    = WORD_BITS'(prod[LCG_BITS-1:0]) + WORD_BITS'(prod[PROD_BITS-1:LCG_BITS]);
    assign lcg_new = (fold >= LCG_MOD) ? LCG_BITS'(fold - LCG_MOD) : fold[LCG_BITS-1:0];

    // byte-wise compare over the valid low bytes only
    assign pat_word = WORD_BITS'(lcg_new);

    always_comb
    begin
        mismatch = 1'b0;
        for (int i = 0; i < WORD_BYTES; i++)
        begin
            if ((VALID_BITS'(i) < valid_cnt) && (read_word[8*i +: 8] != pat_word[8*i +: 8]))
            begin
                mismatch = 1'b1;
            end
        end
        mismatch = mismatch && verify_mode_reg && active;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_size_reg  <= '0;
            verify_mode_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx_t'(wr_index))
                REG_DRIVE_SIZE:  drive_size_reg  <= wr_data[DRIVE_SIZE_BITS-1:0];
                REG_VERIFY_MODE: verify_mode_reg <= wr_data[0];
                default:         ;
            endcase
        end
    end

    // position and sticky error update on each accepted word; the generator advances only while active
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcg_reg <= LCG_SEED;
            pos_reg <= '0;
            err_reg <= 1'b0;
        end
        else if (accept)
        begin
            lcg_reg <= active ? lcg_new : lcg_cur;
            pos_reg <= pos_cur + POSITION_BITS'(valid_cnt);
            err_reg <= err_cur || mismatch;
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pattern_reg     <= active ? lcg_new : '0;
            valid_bytes_reg <= valid_cnt;
            mismatch_reg    <= mismatch;
            error_reg       <= err_cur || mismatch;
            last_reg        <= is_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pattern_word  = pattern_reg;
    assign valid_bytes   = valid_bytes_reg;
    assign word_mismatch = mismatch_reg;
    assign error_seen    = error_reg;
    assign last          = last_reg;

endmodule

`default_nettype wire
